// File: design/jac_pkg.sv
package jac_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int PCT_W     = 8;
    localparam int DIR_W     = 4;
    localparam int LVL_W     = 2;
    localparam int THR_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 2 * PCT_W + DIR_W + 2 * LVL_W;

    localparam int PCT_FULL  = 100;
    localparam int QUO_BITS  = 7;
    localparam int DIV_LAT   = QUO_BITS + 4;
    localparam int FIFO_DEPTH = 16;

    localparam logic [THR_W-1:0] DIR_THR_RST  = THR_W'(30);
    localparam logic [THR_W-1:0] LOW_THR_RST  = THR_W'(2);
    localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(90);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER   = 3'd0,
        CFG_MIN      = 3'd1,
        CFG_MAX      = 3'd2,
        CFG_DIR_THR  = 3'd3,
        CFG_LOW_THR  = 3'd4,
        CFG_HIGH_THR = 3'd5
    } jac_cfg_idx_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_CENTER    = 4'd0,
        DIR_UP        = 4'd1,
        DIR_DOWN      = 4'd2,
        DIR_LEFT      = 4'd3,
        DIR_RIGHT     = 4'd4,
        DIR_UPLEFT    = 4'd5,
        DIR_UPRIGHT   = 4'd6,
        DIR_DOWNLEFT  = 4'd7,
        DIR_DOWNRIGHT = 4'd8
    } jac_dir_t;

    typedef enum logic [LVL_W-1:0] {
        LVL_NONE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_HIGH = 2'd2
    } jac_lvl_t;

    typedef struct packed {
        logic signed [PCT_W-1:0] y;
        logic signed [PCT_W-1:0] x;
    } jac_pct_t;

    typedef struct packed {
        logic [THR_W-1:0] dir;
        logic [THR_W-1:0] low;
        logic [THR_W-1:0] high;
    } jac_thr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jac_fifo_st_t;

endpackage

// File: design/joystick_axis_classifier_core.sv
// channel | ports                        | word
// --------+------------------------------+----------------------------------------------
// in      | s_tvalid s_tready s_tdata    | x_sample, y_sample
// out     | m_tvalid m_tready m_tdata    | x_percent, y_percent, stick_direction,
//         |                              | x_strength, y_strength
// cfg     | cfg_valid cfg_ready          | cfg_index, cfg_data (always ready)
//
// One word per cycle sustained while the output drains; each axis runs its own
// 11-stage pipelined divider (seven quotient-bit stages), then a 16-entry queue and
// an output register.
// Synchronous active-low reset empties pipeline, queue and output and restores the
// calibration defaults.
// s_tready drops while 16 words are in flight or queued, so a stalled output backs up
// the input before the queue can overflow.
module joystick_axis_classifier_core
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // x_sample, y_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // x_percent, y_percent, stick_direction,
                                              // x_strength, y_strength
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data
);

    logic [SAMPLE_BITS-1:0] center_reg, min_reg, max_reg;
    jac_thr_t               thr_reg;
    logic                   pop;
    logic                   fr_valid;
    jac_pct_t               fr_word;
    jac_pct_t               q_word;
    jac_fifo_st_t           q_st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg   <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
            min_reg      <= '0;
            max_reg      <= '1;
            thr_reg.dir  <= DIR_THR_RST;
            thr_reg.low  <= LOW_THR_RST;
            thr_reg.high <= HIGH_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CENTER:   center_reg   <= cfg_data;
                CFG_MIN:      min_reg      <= cfg_data;
                CFG_MAX:      max_reg      <= cfg_data;
                CFG_DIR_THR:  thr_reg.dir  <= cfg_data[THR_W-1:0];
                CFG_LOW_THR:  thr_reg.low  <= cfg_data[THR_W-1:0];
                CFG_HIGH_THR: thr_reg.high <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    jac_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .x_sample (s_tdata[SAMPLE_BITS-1:0]),
        .y_sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .center   (center_reg),
        .cal_min  (min_reg),
        .cal_max  (max_reg),
        .pop      (pop),
        .fr_valid (fr_valid),
        .fr_word  (fr_word)
    );

    jac_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fr_valid),
        .wr_word (fr_word),
        .pop     (pop),
        .rd_word (q_word),
        .status  (q_st)
    );

    jac_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (!q_st.empty),
        .q_word   (q_word),
        .thr      (thr_reg),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_valid |-> !q_st.full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_st.empty)
        else $error("queue underflow");

    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[PCT_W-1:0]) <= PCT_W'(PCT_FULL)
                      && $signed(m_tdata[PCT_W-1:0]) >= -PCT_W'(PCT_FULL)))
        else $error("x percent out of range");

    a_center: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2*PCT_W-1:0] == '0)
            |-> m_tdata[2*PCT_W+DIR_W-1:2*PCT_W] == DIR_CENTER)
        else $error("neutral stick not classified as center");

endmodule

// File: design/jac_div.sv
module jac_div
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] center,
    input  logic [SAMPLE_BITS-1:0] cal_min,
    input  logic [SAMPLE_BITS-1:0] cal_max,
    output logic signed [PCT_W-1:0] percent
);

    localparam int NW = SAMPLE_BITS + QUO_BITS;

    logic                   lt;
    logic [SAMPLE_BITS-1:0] a_next;
    logic [SAMPLE_BITS:0]   den;
    logic [SAMPLE_BITS:0]   den_abs;
    logic                   den_neg;

    logic [SAMPLE_BITS-1:0] a_reg;
    logic [SAMPLE_BITS-1:0] d1_reg;
    logic                   neg1_reg;

    logic [NW-1:0]          num_reg;
    logic [SAMPLE_BITS-1:0] d2_reg;
    logic                   neg2_reg;

    logic [NW-1:0]          rem_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0]    q_reg   [QUO_BITS+1];
    logic [SAMPLE_BITS-1:0] d_reg   [QUO_BITS+1];
    logic                   ovf_reg [QUO_BITS+1];
    logic                   neg_reg [QUO_BITS+1];

    logic [QUO_BITS-1:0]    mag;
    logic [PCT_W-1:0]       pct_next;
    logic [PCT_W-1:0]       percent_reg;

    always_comb begin
        lt      = sample < center;
        a_next  = lt ? center - sample : sample - center;
        den     = lt ? {1'b0, center} - {1'b0, cal_min} : {1'b0, cal_max} - {1'b0, center};
        den_neg = den[SAMPLE_BITS];
        den_abs = den_neg ? -den : den;
    end

    // zero offset: force a nonzero divisor so the quotient is plainly zero
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        d1_reg   <= (a_next == '0) ? SAMPLE_BITS'(1) : den_abs[SAMPLE_BITS-1:0];
        neg1_reg <= lt ^ den_neg;
    end

    always_ff @(posedge aclk) begin
        num_reg  <= NW'(a_reg) * NW'(PCT_FULL);
        d2_reg   <= d1_reg;
        neg2_reg <= neg1_reg;
    end

    // quotient of 128 or more (also zero divisor) saturates
    always_ff @(posedge aclk) begin
        rem_reg[0] <= num_reg;
        q_reg[0]   <= '0;
        d_reg[0]   <= d2_reg;
        ovf_reg[0] <= num_reg >= (NW'(d2_reg) << QUO_BITS);
        neg_reg[0] <= neg2_reg;
    end

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        localparam int B = QUO_BITS - 1 - k;
        logic [NW-1:0] dsh;
        logic          take;

        always_comb begin
            dsh  = NW'(d_reg[k]) << B;
            take = rem_reg[k] >= dsh;
        end

        always_ff @(posedge aclk) begin
            rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
            q_reg[k+1]   <= q_reg[k] | (take ? QUO_BITS'(1) << B : '0);
            d_reg[k+1]   <= d_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_comb begin
        if (ovf_reg[QUO_BITS] || q_reg[QUO_BITS] > QUO_BITS'(PCT_FULL)) begin
            mag = QUO_BITS'(PCT_FULL);
        end else begin
            mag = q_reg[QUO_BITS];
        end
        pct_next = neg_reg[QUO_BITS] ? -PCT_W'(mag) : PCT_W'(mag);
    end

    always_ff @(posedge aclk) begin
        percent_reg <= pct_next;
    end

    assign percent = percent_reg;

endmodule

// File: design/jac_front.sv
module jac_front
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   x_sample,
    input  logic [SAMPLE_BITS-1:0]   y_sample,
    input  logic [SAMPLE_BITS-1:0]   center,
    input  logic [SAMPLE_BITS-1:0]   cal_min,
    input  logic [SAMPLE_BITS-1:0]   cal_max,
    input  logic                     pop,
    output logic                     fr_valid,
    output jac_pct_t                 fr_word
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [CNT_W-1:0]   credit_reg;
    logic [CNT_W-1:0]   credit_next;
    logic [DIV_LAT-1:0] vld_reg;
    logic [DIV_LAT-1:0] vld_next;
    logic               take;

    // words in flight or queued never exceed the queue depth
    assign in_ready = credit_reg < CNT_W'(FIFO_DEPTH);
    assign take     = in_valid && in_ready;

    always_comb begin
        credit_next = credit_reg + CNT_W'(take) - CNT_W'(pop);
        vld_next    = {vld_reg[DIV_LAT-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end else begin
            credit_reg <= credit_next;
            vld_reg    <= vld_next;
        end
    end

    jac_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_x (
        .aclk    (aclk),
        .sample  (x_sample),
        .center  (center),
        .cal_min (cal_min),
        .cal_max (cal_max),
        .percent (fr_word.x)
    );

    jac_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_y (
        .aclk    (aclk),
        .sample  (y_sample),
        .center  (center),
        .cal_min (cal_min),
        .cal_max (cal_max),
        .percent (fr_word.y)
    );

    assign fr_valid = vld_reg[DIV_LAT-1];

endmodule

// File: design/jac_fifo.sv
module jac_fifo
    import jac_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  jac_pct_t     wr_word,
    input  logic         pop,
    output jac_pct_t     rd_word,
    output jac_fifo_st_t status
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    jac_pct_t         mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

    assign rd_word      = mem[rd_ptr_reg];
    assign status.full  = cnt_reg == (PTR_W+1)'(FIFO_DEPTH);
    assign status.empty = cnt_reg == '0;

endmodule

// File: design/jac_back.sv
module jac_back
    import jac_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  jac_pct_t         q_word,
    input  jac_thr_t         thr,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    function automatic jac_lvl_t level_of(input logic signed [PCT_W-1:0] p,
                                          input logic [THR_W-1:0] lo,
                                          input logic [THR_W-1:0] hi);
        logic [PCT_W-1:0] m;
        m = p[PCT_W-1] ? -p : p;
        if (m > PCT_W'(hi)) begin
            return LVL_HIGH;
        end else if (m > PCT_W'(lo)) begin
            return LVL_LOW;
        end
        return LVL_NONE;
    endfunction

    logic signed [PCT_W:0] xs, ys, t;
    logic                  up, down, left, right;
    jac_dir_t              dir;
    jac_lvl_t              x_lvl, y_lvl;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    always_comb begin
        xs    = {q_word.x[PCT_W-1], q_word.x};
        ys    = {q_word.y[PCT_W-1], q_word.y};
        t     = (PCT_W+1)'(thr.dir);
        up    = ys > t;
        down  = ys < -t;
        left  = xs < -t;
        right = xs > t;
        if (up && left) begin
            dir = DIR_UPLEFT;
        end else if (up && right) begin
            dir = DIR_UPRIGHT;
        end else if (down && left) begin
            dir = DIR_DOWNLEFT;
        end else if (down && right) begin
            dir = DIR_DOWNRIGHT;
        end else if (up) begin
            dir = DIR_UP;
        end else if (down) begin
            dir = DIR_DOWN;
        end else if (left) begin
            dir = DIR_LEFT;
        end else if (right) begin
            dir = DIR_RIGHT;
        end else begin
            dir = DIR_CENTER;
        end
        x_lvl = level_of(q_word.x, thr.low, thr.high);
        y_lvl = level_of(q_word.y, thr.low, thr.high);
    end

    assign pop = q_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (pop) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {y_lvl, x_lvl, dir, q_word.y, q_word.x};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jac_pkg::*;

    localparam int SAMPLE_W = 12;
    localparam int RAW_MAX  = (1 << SAMPLE_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic signed [PCT_W-1:0] x_pct;
        logic signed [PCT_W-1:0] y_pct;
        jac_dir_t                dir;
        jac_lvl_t                x_lvl;
        jac_lvl_t                y_lvl;
    } stick_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [2*SAMPLE_W-1:0]   s_tdata = '0;     // x_sample, y_sample
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_W-1:0]        m_tdata;          // x_percent, y_percent, stick_direction,
                                               // x_strength, y_strength
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [SAMPLE_W-1:0]     cfg_data = '0;

    logic [SAMPLE_W-1:0]     cal_center = 12'd2048;
    logic [SAMPLE_W-1:0]     cal_min    = 12'd0;
    logic [SAMPLE_W-1:0]     cal_max    = 12'd4095;
    logic [THR_W-1:0]        thr_dir    = DIR_THR_RST;
    logic [THR_W-1:0]        thr_low    = LOW_THR_RST;
    logic [THR_W-1:0]        thr_high   = HIGH_THR_RST;

    stick_result_t           pending_results[$];
    int                      mismatch_count = 0;
    bit                      src_gaps_on = 1'b1;
    bit                      sink_gaps_on = 1'b1;
    int                      sink_wait = 0;
    int                      hold_cycles = 0;

    joystick_axis_classifier_core #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int axis_percent(logic [SAMPLE_W-1:0] raw);
        int r, c, lo, hi, num, den, p;
        r  = int'(raw);
        c  = int'(cal_center);
        lo = int'(cal_min);
        hi = int'(cal_max);
        if (r < c) begin
            num = -PCT_FULL * (c - r);
            den = c - lo;
            if (den == 0)
                return -PCT_FULL;
        end else begin
            num = PCT_FULL * (r - c);
            den = hi - c;
            if (den == 0)
                return (r == c) ? 0 : PCT_FULL;
        end
        p = num / den;
        if (p > PCT_FULL)
            p = PCT_FULL;
        if (p < -PCT_FULL)
            p = -PCT_FULL;
        return p;
    endfunction

    function automatic jac_lvl_t axis_level(int p);
        int m;
        m = (p < 0) ? -p : p;
        if (m > int'(thr_high))
            return LVL_HIGH;
        if (m > int'(thr_low))
            return LVL_LOW;
        return LVL_NONE;
    endfunction

    function automatic jac_dir_t stick_heading(int x, int y);
        int  t;
        bit  up, down, left, right;
        t     = int'(thr_dir);
        up    = y > t;
        down  = y < -t;
        left  = x < -t;
        right = x > t;
        if (up && left)    return DIR_UPLEFT;
        if (up && right)   return DIR_UPRIGHT;
        if (down && left)  return DIR_DOWNLEFT;
        if (down && right) return DIR_DOWNRIGHT;
        if (up)            return DIR_UP;
        if (down)          return DIR_DOWN;
        if (left)          return DIR_LEFT;
        if (right)         return DIR_RIGHT;
        return DIR_CENTER;
    endfunction

    function automatic stick_result_t predict_stick(logic [SAMPLE_W-1:0] xr,
                                                    logic [SAMPLE_W-1:0] yr);
        stick_result_t res;
        int            xp, yp;
        xp = axis_percent(xr);
        yp = axis_percent(yr);
        res.x_pct = PCT_W'(xp);
        res.y_pct = PCT_W'(yp);
        res.dir   = stick_heading(xp, yp);
        res.x_lvl = axis_level(xp);
        res.y_lvl = axis_level(yp);
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_raw();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1) ? RAW_MAX : 0;
            1: v = int'(cal_center) + $urandom_range(0, 80) - 40;
            2: v = int'(cal_min) + $urandom_range(0, 20) - 10;
            3: v = int'(cal_max) + $urandom_range(0, 20) - 10;
            default: v = $urandom_range(0, RAW_MAX);
        endcase
        if (v < 0)
            v = 0;
        if (v > RAW_MAX)
            v = RAW_MAX;
        return SAMPLE_W'(v);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] xr, input logic [SAMPLE_W-1:0] yr);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yr, xr};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_stick(xr, yr));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CENTER:   cal_center = val;
            CFG_MIN:      cal_min    = val;
            CFG_MAX:      cal_max    = val;
            CFG_DIR_THR:  thr_dir    = val[THR_W-1:0];
            CFG_LOW_THR:  thr_low    = val[THR_W-1:0];
            CFG_HIGH_THR: thr_high   = val[THR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_pipeline_empty();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DIV_LAT + 4) @(posedge aclk);
    endtask

    task automatic load_calibration(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] lo,
                                    input logic [SAMPLE_W-1:0] hi, input logic [SAMPLE_W-1:0] td,
                                    input logic [SAMPLE_W-1:0] tl, input logic [SAMPLE_W-1:0] th);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
        write_reg(CFG_DIR_THR, td);
        write_reg(CFG_LOW_THR, tl);
        write_reg(CFG_HIGH_THR, th);
    endtask

    // receive side: per-word wait plus an optional long hold-off
    always @(negedge aclk) begin
        if (sink_wait > 0)
            sink_wait <= sink_wait - 1;
        m_tready <= (sink_wait == 0) && (hold_cycles == 0);
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge aclk) begin
        stick_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            sink_wait = sink_gaps_on ? $urandom_range(0, 9) : 0;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word %h at %0t", m_tdata, $realtime);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[7:0] !== exp_res.x_pct || m_tdata[15:8] !== exp_res.y_pct ||
                    m_tdata[19:16] !== exp_res.dir || m_tdata[21:20] !== exp_res.x_lvl ||
                    m_tdata[23:22] !== exp_res.y_lvl) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at %0t: exp x=%0d y=%0d dir=%0d xl=%0d yl=%0d",
                                 $realtime, exp_res.x_pct, exp_res.y_pct, exp_res.dir,
                                 exp_res.x_lvl, exp_res.y_lvl);
                        $display("    got x=%0d y=%0d dir=%0d xl=%0d yl=%0d",
                                 $signed(m_tdata[7:0]), $signed(m_tdata[15:8]),
                                 m_tdata[19:16], m_tdata[21:20], m_tdata[23:22]);
                    end
                end
            end
        end
    end

    task automatic test_default_calibration();
        int xs[3] = '{0, 2048, RAW_MAX};
        // all nine headings at full throw
        foreach (xs[i])
            foreach (xs[j])
                send_sample(SAMPLE_W'(xs[i]), SAMPLE_W'(xs[j]));
        // direction and level threshold edges
        send_sample(12'd2662, 12'd2048);
        send_sample(12'd2683, 12'd2048);
        send_sample(12'd2048, 12'd2089);
        send_sample(12'd2048, 12'd2110);
        send_sample(12'd2047, 12'd1433);
        send_sample(12'd3890, 12'd205);
        send_sample(12'hAAA, 12'h555);
        wait_pipeline_empty();
    endtask

    task automatic test_calibration_corners();
        // zero span on both sides
        load_calibration(12'd1000, 12'd1000, 12'd1000, 12'd0, 12'd0, 12'd0);
        send_sample(12'd999, 12'd1000);
        send_sample(12'd1001, 12'd0);
        send_sample(12'd1000, RAW_MAX);
        wait_pipeline_empty();
        // reversed span, upper register bits dropped on thresholds
        load_calibration(12'd1000, 12'd3000, 12'd500, 12'hFFF, 12'hF80, 12'hFE4);
        send_sample(12'd0, 12'd999);
        send_sample(12'd1500, RAW_MAX);
        send_sample(12'd1001, 12'd400);
        wait_pipeline_empty();
        // unused register slots leave the calibration alone
        write_reg(CFG_SPARE_A, RAW_MAX);
        write_reg(CFG_SPARE_B, 12'd0);
        // low threshold above the high one
        load_calibration(12'd0, 12'd0, RAW_MAX, 12'd100, 12'd80, 12'd20);
        send_sample(12'd0, RAW_MAX);
        send_sample(12'd2000, 12'd3500);
        send_sample(12'd4000, 12'd100);
        wait_pipeline_empty();
    endtask

    task automatic test_random_calibrations();
        logic [SAMPLE_W-1:0] c, lo, hi, td, tl, th;
        for (int ph = 0; ph < 6; ph++) begin
            src_gaps_on  = (ph != 2);
            sink_gaps_on = (ph != 3);
            case (ph)
                0: load_calibration(12'd2048, 12'd0, RAW_MAX, 12'd30, 12'd2, 12'd90);
                1: load_calibration(RAW_MAX, 12'd0, RAW_MAX, 12'd100, 12'd100, 12'd100);
                2: load_calibration(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
                default: begin
                    c  = SAMPLE_W'($urandom_range(0, RAW_MAX));
                    lo = ($urandom_range(0, 9) < 8) ? SAMPLE_W'($urandom_range(0, c))
                                                    : SAMPLE_W'($urandom_range(0, RAW_MAX));
                    hi = ($urandom_range(0, 9) < 8) ? SAMPLE_W'($urandom_range(c, RAW_MAX))
                                                    : SAMPLE_W'($urandom_range(0, RAW_MAX));
                    td = ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom_range(0, 127))
                                                     : SAMPLE_W'($urandom_range(0, 100));
                    tl = SAMPLE_W'($urandom_range(0, 30));
                    th = SAMPLE_W'($urandom_range(0, 100));
                    load_calibration(c, lo, hi, td, tl, th);
                end
            endcase
            repeat (110)
                send_sample(pick_raw(), pick_raw());
            wait_pipeline_empty();
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        load_calibration(12'd2048, 12'd100, 12'd3900, 12'd45, 12'd5, 12'd75);
        src_gaps_on = 1'b0;
        @(posedge aclk);
        hold_cycles = 200;
        repeat (60)
            send_sample(SAMPLE_W'($urandom_range(0, RAW_MAX)),
                        SAMPLE_W'($urandom_range(0, RAW_MAX)));
        src_gaps_on = 1'b1;
        wait_pipeline_empty();
    endtask

    initial begin
        #5_000_000;
        $display("joystick_axis_classifier_core verification failed");
        $finish;
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        test_default_calibration();
        test_calibration_corners();
        test_random_calibrations();
        test_output_backpressure();
        wait_pipeline_empty();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("joystick_axis_classifier_core verification clean");
        else
            $display("joystick_axis_classifier_core verification failed");
        $finish;
    end

endmodule
